// ===== rtl/dfps_pkg.sv =====
// Shared types, codes and helpers of the dataflash page sequencer.
`timescale 1ns / 1ps

package dfps_pkg;

  // Item codes on the request channel.
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_XFER  = 2'd2;

  // Flash opcodes and status bits.
  localparam logic [7:0] OP_STATUS    = 8'h57;
  localparam logic [7:0] OP_READ      = 8'h68;
  localparam logic [7:0] OP_PROG      = 8'h82;
  localparam logic [7:0] STATUS_READY = 8'h80;

  // Number of address bytes after the opcode.
  localparam int ADDR_BYTES = 3;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_POLL_CMD  = 3'd1,
    PH_POLL_STAT = 3'd2,
    PH_OPCODE    = 3'd3,
    PH_ADDR      = 3'd4,
    PH_DUMMY     = 3'd5,
    PH_DATA      = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] page;
    logic [7:0]  write_byte;
    logic [7:0]  miso_byte;
  } dfps_in_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       send;
    logic       frame_start;
    logic       select;
    logic       write_taken;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
  } dfps_out_t;

  // Transfer context held between items.
  typedef struct packed {
    phase_t      phase;
    logic        is_write;
    logic [11:0] page;
  } dfps_ctx_t;

  // Address byte k of page << 9, most significant first.
  function automatic logic [7:0] addr_byte(input logic [11:0] page, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = {3'b000, page[11:7]};
      2'd1:    b = {page[6:0], 1'b0};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/dfps_step.sv =====
// Next-state and result logic for one byte exchange event.
`timescale 1ns / 1ps

module dfps_step #(
  parameter int PAGE_BYTES       = 264,
  parameter int READ_DUMMY_BYTES = 4,
  parameter int CNT_W            = 9
) (
  input  dfps_pkg::dfps_in_t  item,
  input  dfps_pkg::dfps_ctx_t ctx,
  input  logic [CNT_W-1:0]    cnt,
  output dfps_pkg::dfps_ctx_t ctx_next,
  output logic [CNT_W-1:0]    cnt_next,
  output logic                has_result,
  output dfps_pkg::dfps_out_t res
);
  import dfps_pkg::*;

  localparam bit HAS_DUMMY = (READ_DUMMY_BYTES > 0);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_ADDR  = CNT_W'(ADDR_BYTES);
  localparam logic [CNT_W-1:0] CNT_DUMMY = CNT_W'(READ_DUMMY_BYTES);
  localparam logic [CNT_W-1:0] CNT_PAGE  = CNT_W'(PAGE_BYTES);

  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = cnt + CNT_ONE;

  always_comb begin
    ctx_next   = ctx;
    cnt_next   = cnt;
    has_result = 1'b1;
    res        = '0;
    res.send   = 1'b1;
    res.select = 1'b1;

    unique case (ctx.phase)
      PH_POLL_CMD, PH_POLL_STAT, PH_OPCODE, PH_ADDR, PH_DUMMY, PH_DATA: begin
        if (item.mode != MODE_XFER) begin
          has_result = 1'b0;
        end else begin
          unique case (ctx.phase)
            PH_POLL_CMD: begin
              ctx_next.phase = PH_POLL_STAT;
            end
            PH_POLL_STAT: begin
              res.frame_start = 1'b1;
              if ((item.miso_byte & STATUS_READY) != 8'h00) begin
                ctx_next.phase = PH_OPCODE;
                res.mosi_byte  = ctx.is_write ? OP_PROG : OP_READ;
              end else begin
                ctx_next.phase = PH_POLL_CMD;
                res.mosi_byte  = OP_STATUS;
              end
            end
            PH_OPCODE: begin
              ctx_next.phase = PH_ADDR;
              res.mosi_byte  = addr_byte(ctx.page, 2'd0);
              cnt_next       = CNT_ONE;
            end
            PH_ADDR: begin
              if (cnt < CNT_ADDR) begin
                res.mosi_byte = addr_byte(ctx.page, cnt[1:0]);
                cnt_next      = cnt_inc;
              end else if (!ctx.is_write && HAS_DUMMY) begin
                ctx_next.phase = PH_DUMMY;
                cnt_next       = CNT_ONE;
              end else begin
                ctx_next.phase  = PH_DATA;
                cnt_next        = CNT_ONE;
                res.mosi_byte   = ctx.is_write ? item.write_byte : 8'h00;
                res.write_taken = ctx.is_write;
              end
            end
            PH_DUMMY: begin
              if (cnt < CNT_DUMMY) begin
                cnt_next = cnt_inc;
              end else begin
                ctx_next.phase  = PH_DATA;
                cnt_next        = CNT_ONE;
                res.mosi_byte   = ctx.is_write ? item.write_byte : 8'h00;
                res.write_taken = ctx.is_write;
              end
            end
            default: begin
              if (!ctx.is_write) begin
                res.read_byte  = item.miso_byte;
                res.read_valid = 1'b1;
              end
              if (cnt < CNT_PAGE) begin
                cnt_next        = cnt_inc;
                res.mosi_byte   = ctx.is_write ? item.write_byte : 8'h00;
                res.write_taken = ctx.is_write;
              end else begin
                res.send       = 1'b0;
                res.select     = 1'b0;
                res.done_res   = 1'b1;
                ctx_next.phase = PH_IDLE;
                cnt_next       = '0;
              end
            end
          endcase
        end
      end
      default: begin
        // Idle: only a start request does anything.
        if (item.mode == MODE_READ || item.mode == MODE_WRITE) begin
          ctx_next.phase    = PH_POLL_CMD;
          ctx_next.is_write = (item.mode == MODE_WRITE);
          ctx_next.page     = item.page;
          cnt_next          = '0;
          res.mosi_byte     = OP_STATUS;
          res.frame_start   = 1'b1;
        end else begin
          has_result = 1'b0;
        end
      end
    endcase
  end

endmodule

// ===== rtl/dfps_out_reg.sv =====
// Result register that holds a transfer until the consumer takes it.
`timescale 1ns / 1ps

module dfps_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  dfps_pkg::dfps_out_t load_data,
  input  logic                rsp_stall,
  output logic                free,
  output logic                rsp_valid,
  output dfps_pkg::dfps_out_t rsp
);
  import dfps_pkg::*;

  logic rsp_valid_next;

  // Slot is free when empty or when its contents leave this cycle.
  assign free = !rsp_valid || !rsp_stall;

  always_comb begin
    if (load) begin
      rsp_valid_next = 1'b1;
    end else begin
      rsp_valid_next = rsp_valid && rsp_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= load_data;
    end
  end

endmodule

// ===== rtl/dataflash_page_sequencer_core.sv =====
// Top level of the dataflash page sequencer: input register, step logic, result register.
`timescale 1ns / 1ps

// Dataflash page sequencer. Each request transfer is one event: a start of a
// page read (mode 0) or page program (mode 1), or the completion of the byte
// exchange that the previous result launched (mode 2, with the byte received
// from the flash). For every event that matters the block answers with one
// result transfer naming the next byte to shift out, whether to open a fresh
// chip-select frame first, the chip-select level, whether write_byte was
// used, and any page byte read back. A page operation polls status (0x57 and
// a dummy byte per frame) until bit 7 is set, sends the opcode and three
// address bytes, four dummy bytes on a read, then PAGE_BYTES data bytes;
// the last result raises done_res with the chip deselected. Starts while busy,
// completions while idle and mode 3 are swallowed with no result. One request
// is taken every clock cycle while req_stall is low: the work for an item sits
// between the input register and the result register, so each request
// transfer passes through both on its way to a result, and a held result does
// not block the next request until both registers are full.

module dataflash_page_sequencer_core #(
  parameter int PAGE_BYTES       = 264,
  parameter int READ_DUMMY_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  dfps_pkg::dfps_in_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output dfps_pkg::dfps_out_t rsp
);
  import dfps_pkg::*;

  // Counter spans the page length and the dummy and address counts.
  localparam int CNT_MAX = (PAGE_BYTES > 8) ? PAGE_BYTES : 8;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  // Input register.
  logic      s1_valid;
  dfps_in_t  s1_item;

  // Transfer context and byte counter.
  dfps_ctx_t        ctx;
  dfps_ctx_t        ctx_next;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;

  logic      has_result;
  dfps_out_t step_res;
  logic      out_free;
  logic      advance;
  logic      req_take;

  // Process the held item once the result slot can take its answer.
  assign advance   = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_item <= req;
    end
  end

  dfps_step #(
    .PAGE_BYTES       (PAGE_BYTES),
    .READ_DUMMY_BYTES (READ_DUMMY_BYTES),
    .CNT_W            (CNT_W)
  ) u_step (
    .item       (s1_item),
    .ctx        (ctx),
    .cnt        (byte_count),
    .ctx_next   (ctx_next),
    .cnt_next   (byte_count_next),
    .has_result (has_result),
    .res        (step_res)
  );

  // Advance the context only when the item is actually processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.phase    <= PH_IDLE;
      ctx.is_write <= 1'b0;
      ctx.page     <= '0;
      byte_count   <= '0;
    end else if (advance) begin
      ctx        <= ctx_next;
      byte_count <= byte_count_next;
    end
  end

  dfps_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .load_data (step_res),
    .rsp_stall (rsp_stall),
    .free      (out_free),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // Finishing a page returns the sequencer to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    advance && has_result && step_res.done_res |=> ctx.phase == PH_IDLE)
    else $error("sequencer not idle after page end");

  // A consumed write byte only ever belongs to a program operation.
  a_taken_write: assert property (@(posedge clk) disable iff (rst)
    advance && has_result && step_res.write_taken |=> ctx.is_write)
    else $error("write byte consumed outside a program");

  // Counter never runs past its largest meaningful value.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(CNT_MAX))
    else $error("byte counter out of range");

  // A held result blocks the input register only when it is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("request stalled with room to spare");

  // A finished page releases the chip and launches nothing.
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    advance && has_result && step_res.done_res |=> rsp_valid && !rsp.send && !rsp.select)
    else $error("page end result still drives the flash");

endmodule

// ===== verif/dataflash_page_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the dataflash page sequencer core with its own sequencer model.

// Drive whole page reads and page programs through the core, one flash byte
// exchange per request transfer. Mix in events that the core must swallow.
// Predict every result transfer from a local model of the sequencer and check
// it field by field. The request side and the result side each idle at random,
// in three stages of the run.
module dataflash_page_sequencer_core_tb;
  import dfps_pkg::*;

  localparam int PAGE_LEN    = 264;
  localparam int DUMMY_LEN   = 4;
  localparam int ITEM_TARGET = 2000;
  // A gap of this many cycles with no transfer on either side means a hang.
  // The worst correct gap is a short run of random idles on both sides
  // plus the pipeline through the input and result registers, far below this limit.
  localparam int STALL_LIMIT = 1000;
  // Pipeline depth is two registers. SETTLE_CYCLES leaves time for a stray result.
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_CAP     = 100;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  dfps_in_t  req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  dfps_out_t rsp;

  dataflash_page_sequencer_core #(
    .PAGE_BYTES       (PAGE_LEN),
    .READ_DUMMY_BYTES (DUMMY_LEN)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // Local copy of the sequencer state. It is kept in step with every request
  // transfer that the core accepts.
  phase_t      seq_phase = PH_IDLE;
  logic        seq_write = 1'b0;
  logic [11:0] seq_page  = '0;
  logic [8:0]  seq_count = '0;

  dfps_in_t  event_q[$];   // flash events still to be offered
  dfps_out_t launch_q[$];  // predicted results, oldest first
  dfps_out_t next_launch;
  dfps_out_t planned;

  int counted_items = 0;
  int total_events  = 0;
  int accepted_cnt  = 0;
  int result_cnt    = 0;
  int mismatch_cnt  = 0;
  int quiet_cycles  = 0;

  logic [1:0] ignored_modes [3] = '{MODE_READ, MODE_WRITE, MODE_UNUSED};

  // ---------------------------------------------------------------------
  // Sequencer model
  // ---------------------------------------------------------------------

  // Return address byte k of page << 9, most significant byte first.
  function automatic logic [7:0] page_addr_byte(input int k);
    if (k == 0) return {3'b000, seq_page[11:7]};
    if (k == 1) return {seq_page[6:0], 1'b0};
    return 8'h00;
  endfunction

  // Enter the data phase and launch the first data byte.
  function automatic void open_data(input logic [7:0] wbyte, inout dfps_out_t r);
    seq_phase = PH_DATA;
    seq_count = 9'd1;
    if (seq_write) begin
      r.mosi_byte   = wbyte;
      r.write_taken = 1'b1;
    end else begin
      r.mosi_byte = 8'h00;
    end
  endfunction

  // Advance the model by one flash event. Return 1 when the core must answer
  // with a result transfer, and return that result in r.
  function automatic bit step_sequencer(input dfps_in_t ev, output dfps_out_t r);
    r        = '0;
    r.send   = 1'b1;
    r.select = 1'b1;
    if (seq_phase > PH_DATA) seq_phase = PH_IDLE;

    // When idle, accept only a start. Latch the direction and the page,
    // then open the first status poll frame.
    if (seq_phase == PH_IDLE) begin
      if (ev.mode != MODE_READ && ev.mode != MODE_WRITE) return 1'b0;
      seq_write     = (ev.mode == MODE_WRITE);
      seq_page      = ev.page;
      seq_count     = '0;
      seq_phase     = PH_POLL_CMD;
      r.mosi_byte   = OP_STATUS;
      r.frame_start = 1'b1;
      return 1'b1;
    end

    // When busy, advance only on a completed exchange.
    if (ev.mode != MODE_XFER) return 1'b0;
    case (seq_phase)
      PH_POLL_CMD: begin
        seq_phase   = PH_POLL_STAT;
        r.mosi_byte = 8'h00;
      end
      PH_POLL_STAT: begin
        r.frame_start = 1'b1;
        if ((ev.miso_byte & STATUS_READY) != 8'h00) begin
          seq_phase   = PH_OPCODE;
          r.mosi_byte = seq_write ? OP_PROG : OP_READ;
        end else begin
          seq_phase   = PH_POLL_CMD;
          r.mosi_byte = OP_STATUS;
        end
      end
      PH_OPCODE: begin
        seq_phase   = PH_ADDR;
        r.mosi_byte = page_addr_byte(0);
        seq_count   = 9'd1;
      end
      PH_ADDR: begin
        if (seq_count < ADDR_BYTES) begin
          r.mosi_byte = page_addr_byte(int'(seq_count));
          seq_count++;
        end else if (!seq_write && DUMMY_LEN > 0) begin
          seq_phase   = PH_DUMMY;
          r.mosi_byte = 8'h00;
          seq_count   = 9'd1;
        end else begin
          open_data(ev.write_byte, r);
        end
      end
      PH_DUMMY: begin
        if (seq_count < DUMMY_LEN) begin
          r.mosi_byte = 8'h00;
          seq_count++;
        end else begin
          open_data(ev.write_byte, r);
        end
      end
      default: begin
        if (!seq_write) begin
          r.read_byte  = ev.miso_byte;
          r.read_valid = 1'b1;
        end
        if (seq_count < PAGE_LEN) begin
          seq_count++;
          if (seq_write) begin
            r.mosi_byte   = ev.write_byte;
            r.write_taken = 1'b1;
          end
        end else begin
          // The last read byte and done travel in the same result.
          r.send     = 1'b0;
          r.select   = 1'b0;
          r.done_res = 1'b1;
          seq_phase  = PH_IDLE;
          seq_count  = '0;
        end
      end
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------

  // Build an event with the given mode and received byte. Give the other
  // fields random values.
  function automatic dfps_in_t make_item(input logic [1:0] m, input logic [7:0] miso);
    dfps_in_t it;
    it.mode       = m;
    it.page       = 12'($urandom);
    it.write_byte = 8'($urandom);
    it.miso_byte  = miso;
    return it;
  endfunction

  // Queue an exchange completion while the core is busy. Sometimes put a
  // start or an unused mode before it, which the core must drop.
  task automatic push_busy(input dfps_in_t it, input int noise_pct);
    if ($urandom_range(99) < noise_pct)
      event_q.push_back(make_item(ignored_modes[2'($urandom_range(2))], 8'($urandom)));
    event_q.push_back(it);
    counted_items++;
  endtask

  // Queue one whole page operation: the start, status polls that come back
  // busy and then ready, the opcode, the address, the dummy bytes on a read,
  // and the data bytes.
  task automatic queue_page_op(input bit wr, input logic [11:0] pg,
                               input int not_ready, input int noise_pct);
    dfps_in_t start_ev;
    int       body_len;
    start_ev      = make_item(wr ? MODE_WRITE : MODE_READ, 8'($urandom));
    start_ev.page = pg;
    event_q.push_back(start_ev);
    counted_items++;
    for (int i = 0; i < not_ready; i++) begin
      push_busy(make_item(MODE_XFER, 8'($urandom)), noise_pct);
      push_busy(make_item(MODE_XFER, 8'($urandom_range(0, 127))), noise_pct);
    end
    push_busy(make_item(MODE_XFER, 8'($urandom)), noise_pct);
    push_busy(make_item(MODE_XFER, STATUS_READY | 8'($urandom)), noise_pct);
    body_len = 1 + ADDR_BYTES + (wr ? 0 : DUMMY_LEN) + PAGE_LEN;
    for (int i = 0; i < body_len; i++)
      push_busy(make_item(MODE_XFER, 8'($urandom)), noise_pct);
  endtask

  // ---------------------------------------------------------------------
  // Idling: three stages by share of the events accepted so far
  // ---------------------------------------------------------------------

  function automatic int idle_stage();
    return (accepted_cnt * 3) / total_events;
  endfunction

  function automatic int sender_idle_pct();
    case (idle_stage())
      0:       return 19;
      1:       return 67;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (idle_stage())
      0:       return 67;
      1:       return 19;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------

  // Sample the handshake at the edge with the values from before the edge.
  // On a transfer, advance the model. Offer the next event only when the
  // slot is free. Hold a stalled event unchanged.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        accepted_cnt++;
        if (step_sequencer(req, next_launch)) launch_q.push_back(next_launch);
      end
      if (!req_valid || !req_stall) begin
        if (event_q.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          req       <= event_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------

  // Print one line for a mismatch and count it. Print no more than the cap.
  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $time, result_cnt, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) note_mismatch(what, got, want);
  endtask

  // Compare each result transfer with the oldest prediction. Draw the result
  // stall afresh every cycle, independent of the result valid.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (launch_q.size() == 0) begin
          note_mismatch("result with nothing pending", rsp.mosi_byte, 8'h00);
        end else begin
          planned = launch_q.pop_front();
          check_field("mosi_byte",   rsp.mosi_byte,       planned.mosi_byte);
          check_field("send",        8'(rsp.send),        8'(planned.send));
          check_field("frame_start", 8'(rsp.frame_start), 8'(planned.frame_start));
          check_field("select",      8'(rsp.select),      8'(planned.select));
          check_field("write_taken", 8'(rsp.write_taken), 8'(planned.write_taken));
          check_field("read_byte",   rsp.read_byte,       planned.read_byte);
          check_field("read_valid",  8'(rsp.read_valid),  8'(planned.read_valid));
          check_field("done_res",    8'(rsp.done_res),    8'(planned.done_res));
        end
        result_cnt++;
      end
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Event list, reset and end of run
  // ---------------------------------------------------------------------

  initial begin
    // Directed opening. Send a completion and an unused mode while idle.
    // Then read the top page through two busy polls. Then program page zero
    // at once. Let both operations carry some dropped events.
    event_q.push_back(make_item(MODE_XFER, 8'hFF));
    event_q.push_back(make_item(MODE_UNUSED, 8'h00));
    queue_page_op(1'b0, 12'hFFF, 2, 5);
    queue_page_op(1'b1, 12'h000, 0, 5);

    // Random operations. Most are well formed with random content. Some
    // carry dropped starts and unused modes. Some are followed by events
    // sent while idle.
    while (counted_items < ITEM_TARGET) begin
      queue_page_op(1'($urandom), ($urandom_range(9) == 0) ? {12{1'($urandom)}}
                                                           : 12'($urandom),
                    ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 2),
                    $urandom_range(0, 8));
      if ($urandom_range(99) < 30)
        event_q.push_back(make_item($urandom_range(1) ? MODE_XFER : MODE_UNUSED,
                                    8'($urandom)));
    end
    total_events = event_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every event to be taken and every prediction to be met.
    // Then wait out SETTLE_CYCLES for any stray result.
    wait (accepted_cnt == total_events);
    while (launch_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
